[rtl/rv32im_zicond_alu_defines.svh]
// Assertion macros used by the ALU top level.
// Depends on nothing; included by files that carry assertions.
`ifndef RV32IM_ZICOND_ALU_DEFINES_SVH
`define RV32IM_ZICOND_ALU_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define ALU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ALU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/alu_pkg.sv]
// Package for the RV32IM Zicond ALU: operation codes, widths and cell types.
// Depends on nothing.
package alu_pkg;

    localparam int XLEN = 32;
    localparam int CMD_W = 5;

    typedef enum logic [CMD_W-1:0] {
        OP_ADD = 5'd0, OP_SUB = 5'd1, OP_SLL = 5'd2, OP_SRL = 5'd3,
        OP_SRA = 5'd4, OP_SLT = 5'd5, OP_SLTU = 5'd6, OP_AND = 5'd7,
        OP_OR = 5'd8, OP_XOR = 5'd9, OP_MUL = 5'd10, OP_MULH = 5'd11,
        OP_MULHSU = 5'd12, OP_MULHU = 5'd13, OP_DIV = 5'd14, OP_REM = 5'd15,
        OP_DIVU = 5'd16, OP_REMU = 5'd17, OP_CZEQZ = 5'd18, OP_CZNEZ = 5'd19
    } t_op;

    // Payload carried from cell to cell along the divider chain.
    typedef struct packed {
        logic             valid;
        logic             is_div;     // division transaction, not a bypass one
        logic             want_rem;
        logic             neg_q;
        logic             neg_r;
        logic             special;    // result known up front
        logic [XLEN-1:0]  fixed;      // bypass or special result
        logic [XLEN-1:0]  rem;        // partial remainder
        logic [XLEN-1:0]  quo;        // dividend shifting out, quotient in
        logic [XLEN-1:0]  dvs;        // divisor magnitude
    } t_cell;

endpackage

[rtl/alu_if.sv]
// Valid/ready channel interface carrying an ALU payload.
// Depends on nothing; width given by parameter.
interface alu_if #(parameter int W = 32) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/alu_in_if.sv]
// Input channel interface: command and two operands.
// Depends on alu_pkg.
interface alu_in_if (input logic i_clk);
    logic                         valid;
    logic                         ready;
    logic [alu_pkg::CMD_W-1:0]    command;
    logic [alu_pkg::XLEN-1:0]     operand_a;
    logic [alu_pkg::XLEN-1:0]     operand_b;
    modport source (output valid, output command, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input command, input operand_a, input operand_b,
                    output ready);
endinterface

[rtl/alu_div_cell.sv]
// One restoring-division cell: one quotient bit per cell, registered.
// Depends on alu_pkg.
module alu_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  alu_pkg::t_cell  i_cell,
    output alu_pkg::t_cell  o_cell
);
    alu_pkg::t_cell r_cell;
    alu_pkg::t_cell n_cell;
    logic [alu_pkg::XLEN:0] trial;
    logic [alu_pkg::XLEN:0] shifted;

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb begin
        n_cell  = i_cell;
        shifted = {i_cell.rem, i_cell.quo[alu_pkg::XLEN-1]};
        trial   = shifted - {1'b0, i_cell.dvs};
        if (i_cell.is_div) begin
            if (!trial[alu_pkg::XLEN]) begin
                n_cell.rem = trial[alu_pkg::XLEN-1:0];
                n_cell.quo = {i_cell.quo[alu_pkg::XLEN-2:0], 1'b1};
            end else begin
                n_cell.rem = shifted[alu_pkg::XLEN-1:0];
                n_cell.quo = {i_cell.quo[alu_pkg::XLEN-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_en) begin
            r_cell.is_div   <= n_cell.is_div;
            r_cell.want_rem <= n_cell.want_rem;
            r_cell.neg_q    <= n_cell.neg_q;
            r_cell.neg_r    <= n_cell.neg_r;
            r_cell.special  <= n_cell.special;
            r_cell.fixed    <= n_cell.fixed;
            r_cell.rem      <= n_cell.rem;
            r_cell.quo      <= n_cell.quo;
            r_cell.dvs      <= n_cell.dvs;
        end
    end

    assign o_cell = r_cell;
endmodule

[rtl/alu_front.sv]
// Front stage: decodes the command, computes the bypass results, including products, and
// prepares division operands. Depends on alu_pkg.
module alu_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [alu_pkg::CMD_W-1:0]   i_command,
    input  logic [alu_pkg::XLEN-1:0]    i_a,
    input  logic [alu_pkg::XLEN-1:0]    i_b,
    output alu_pkg::t_cell              o_cell
);
    localparam int X = alu_pkg::XLEN;

    alu_pkg::t_cell r_cell;
    alu_pkg::t_cell n_cell;
    logic [X-1:0]   r_mul_lo;
    logic [X-1:0]   n_mul_lo;
    logic [X-1:0]   r_mul_hi;
    logic [X-1:0]   n_mul_hi;
    logic           r_sel_mul;
    logic           n_sel_mul;
    logic           r_sel_hi;
    logic           n_sel_hi;
    logic [4:0]     sh;
    logic [2*X-1:0] prod;
    logic [X:0]     ma;
    logic [X:0]     mb;
    logic [X-1:0]   mag_a;
    logic [X-1:0]   mag_b;
    logic           sgn_a;
    logic           sgn_b;
    logic           b_zero;
    logic           signed_div;

    // Multiplier with a 33x33 signed product so every high variant fits.
    always_comb begin
        ma = {1'b0, i_a};
        mb = {1'b0, i_b};
        if (i_command == alu_pkg::OP_MULH || i_command == alu_pkg::OP_MULHSU) begin
            ma = {i_a[X-1], i_a};
        end
        if (i_command == alu_pkg::OP_MULH) begin
            mb = {i_b[X-1], i_b};
        end
    end
    assign prod = (2*X)'($signed(ma) * $signed(mb));

    // Bypass results, product selection and division preparation.
    always_comb begin
        sh         = i_b[4:0];
        b_zero     = (i_b == '0);
        signed_div = (i_command == alu_pkg::OP_DIV) || (i_command == alu_pkg::OP_REM);
        sgn_a      = signed_div && i_a[X-1];
        sgn_b      = signed_div && i_b[X-1];
        mag_a      = sgn_a ? (X'(0) - i_a) : i_a;
        mag_b      = sgn_b ? (X'(0) - i_b) : i_b;
        n_sel_mul  = 1'b0;
        n_sel_hi   = 1'b0;
        n_mul_lo   = prod[X-1:0];
        n_mul_hi   = prod[2*X-1:X];

        n_cell          = '0;
        n_cell.valid    = i_valid;
        n_cell.quo      = mag_a;
        n_cell.dvs      = mag_b;
        n_cell.want_rem = (i_command == alu_pkg::OP_REM) || (i_command == alu_pkg::OP_REMU);
        n_cell.neg_q    = sgn_a ^ sgn_b;
        n_cell.neg_r    = sgn_a;

        unique case (i_command) inside
            alu_pkg::OP_ADD:   n_cell.fixed = i_a + i_b;
            alu_pkg::OP_SUB:   n_cell.fixed = i_a - i_b;
            alu_pkg::OP_SLL:   n_cell.fixed = i_a << sh;
            alu_pkg::OP_SRL:   n_cell.fixed = i_a >> sh;
            alu_pkg::OP_SRA:   n_cell.fixed = X'($signed(i_a) >>> sh);
            alu_pkg::OP_SLT:   n_cell.fixed = X'($signed(i_a) < $signed(i_b));
            alu_pkg::OP_SLTU:  n_cell.fixed = X'(i_a < i_b);
            alu_pkg::OP_AND:   n_cell.fixed = i_a & i_b;
            alu_pkg::OP_OR:    n_cell.fixed = i_a | i_b;
            alu_pkg::OP_XOR:   n_cell.fixed = i_a ^ i_b;
            alu_pkg::OP_MUL:   n_sel_mul = 1'b1;
            alu_pkg::OP_MULH, alu_pkg::OP_MULHSU, alu_pkg::OP_MULHU: begin
                n_sel_mul = 1'b1;
                n_sel_hi  = 1'b1;
            end
            alu_pkg::OP_DIV, alu_pkg::OP_DIVU: begin
                n_cell.is_div = 1'b1;
                if (b_zero) begin
                    n_cell.special = 1'b1;
                    n_cell.fixed   = '1;
                end else if (signed_div && i_a == {1'b1, {(X-1){1'b0}}} && i_b == '1) begin
                    n_cell.special = 1'b1;
                    n_cell.fixed   = i_a;
                end
            end
            alu_pkg::OP_REM, alu_pkg::OP_REMU: begin
                n_cell.is_div = 1'b1;
                if (b_zero) begin
                    n_cell.special = 1'b1;
                    n_cell.fixed   = i_a;
                end else if (signed_div && i_a == {1'b1, {(X-1){1'b0}}} && i_b == '1) begin
                    n_cell.special = 1'b1;
                    n_cell.fixed   = '0;
                end
            end
            alu_pkg::OP_CZEQZ: n_cell.fixed = b_zero ? '0 : i_a;
            alu_pkg::OP_CZNEZ: n_cell.fixed = b_zero ? i_a : '0;
            default:           n_cell.fixed = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_en) begin
            r_cell.is_div   <= n_cell.is_div;
            r_cell.want_rem <= n_cell.want_rem;
            r_cell.neg_q    <= n_cell.neg_q;
            r_cell.neg_r    <= n_cell.neg_r;
            r_cell.special  <= n_cell.special;
            r_cell.fixed    <= n_cell.fixed;
            r_cell.rem      <= n_cell.rem;
            r_cell.quo      <= n_cell.quo;
            r_cell.dvs      <= n_cell.dvs;
            r_mul_lo        <= n_mul_lo;
            r_mul_hi        <= n_mul_hi;
            r_sel_mul       <= n_sel_mul;
            r_sel_hi        <= n_sel_hi;
        end
    end

    // The product joins the chain's bypass result after its register.
    always_comb begin
        o_cell = r_cell;
        if (r_sel_mul) begin
            o_cell.fixed = r_sel_hi ? r_mul_hi : r_mul_lo;
        end
    end
endmodule

[rtl/rv32im_zicond_alu.sv]
// Top level of the RV32IM Zicond ALU: front stage, a chain of division cells and an output fix-up
// register. Depends on alu_pkg, alu_in_if, alu_if, alu_front, alu_div_cell, the defines header.
//
// Channel | Dir | Fields                          | Handshake
// in_ch   | in  | command, operand_a, operand_b   | valid/ready
// out_ch  | out | result                          | valid/ready
//
// One transaction enters per cycle while the chain advances; every operation passes through
// the front stage, 32 division cells and one output register.
// The chain advances as a whole; it holds while the output register is full
// and not being taken, so ready falls only then.
// Reset clears the valid bits of every stage.
`include "rv32im_zicond_alu_defines.svh"
module rv32im_zicond_alu (
    input  logic     i_clk,
    input  logic     i_rst_n,
    alu_in_if.sink   in_ch,
    alu_if.source    out_ch
);
    localparam int X = alu_pkg::XLEN;

    alu_pkg::t_cell chain [0:X];
    logic           adv;
    logic           r_out_valid;
    logic [X-1:0]   r_result;
    logic [X-1:0]   n_result;
    alu_pkg::t_cell last;

    assign adv         = !r_out_valid || out_ch.ready;
    assign in_ch.ready = adv;

    alu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_valid   (in_ch.valid),
        .i_command (in_ch.command),
        .i_a       (in_ch.operand_a),
        .i_b       (in_ch.operand_b),
        .o_cell    (chain[0])
    );

    // Row of division cells, one quotient bit each.
    for (genvar g = 0; g < X; g++) begin : g_cell
        alu_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_cell  (chain[g]),
            .o_cell  (chain[g+1])
        );
    end

    // Sign correction and result selection at the end of the chain.
    always_comb begin
        last = chain[X];
        if (!last.is_div || last.special) begin
            n_result = last.fixed;
        end else if (last.want_rem) begin
            n_result = last.neg_r ? (X'(0) - last.rem) : last.rem;
        end else begin
            n_result = last.neg_q ? (X'(0) - last.quo) : last.quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= last.valid;
        end
        if (adv) begin
            r_result <= n_result;
        end
    end

    assign out_ch.valid = r_out_valid;
    assign out_ch.data  = r_result;

    `ALU_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !r_out_valid, in_ch.ready,
        "ALU stalls with an empty output register")
    `ALU_ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, r_out_valid && !out_ch.ready,
        r_out_valid && $stable(r_result), "ALU result changed during a stall")
    `ALU_ASSERT_NEXT(a_first_cell_moves, i_clk, i_rst_n, in_ch.valid && in_ch.ready,
        chain[0].valid, "accepted transaction missing from front stage")
endmodule
